// ===== design/block_average_level_meter_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the block average level meter
// Shared property wrappers on the clk and rst_n of the including module.
// ---------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_LEVEL_METER_CORE_ASSERT_SVH
`define BLOCK_AVERAGE_LEVEL_METER_CORE_ASSERT_SVH

// Property checked outside reset only.
`define BALM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property that must also hold while reset is asserted.
`define BALM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/balm_pkg.sv =====
// ---------------------------------------------------------------------------
// Block average level meter package
// Sizes, register indexes, reset values, state codes and the control word
// that drives the serial sum and divide unit.
// ---------------------------------------------------------------------------
package balm_pkg;

    // Fixed field and state widths.
    localparam int LEVEL_BITS   = 16;
    localparam int CFG_BITS     = 16;
    localparam int SUM_BITS     = 32;
    localparam int STEP_BITS    = $clog2(SUM_BITS);
    localparam int CFG_IDX_BITS = 1;
    localparam int FLAG_BITS    = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_THRESHOLD = 1'd1;

    // Reset values and the shortest window that setup allows.
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 16'd1024;
    localparam logic [CFG_BITS-1:0] CLIP_RESET   = 16'd32440;
    localparam logic [CFG_BITS-1:0] MIN_WINDOW   = 16'd100;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } balm_state_t;

    // Control word from the sequencer to the serial unit.
    typedef struct packed {
        logic load;      // take a new magnitude, clear carry and remainder
        logic add_step;  // one bit of the serial add
        logic add_last;  // final add bit, saturate on carry out
        logic div_step;  // one bit of the restoring division
        logic clear;     // window closed, empty the sum
    } balm_ctrl_t;

endpackage

// ===== design/block_average_level_meter_core.sv =====
// ---------------------------------------------------------------------------
// Block average level meter core
// Averages sample magnitudes over a configurable window and keeps a
// sticky clip flag; one result word for every sample word.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Signals                        | Content
//  ---------+-----------+--------------------------------+---------------------
//  s_       | in        | s_tvalid s_tready s_tdata      | sample
//  m_       | out       | m_tvalid m_tready m_tdata m_tuser | level, flags
//  cfg_     | in        | cfg_we cfg_index cfg_data      | register writes
//
//  A sample word passes from acceptance through the bit-serial add and
//  the hand-off of the result back to idle, where the next word is taken.
//  A word that closes a window also passes through the one-bit-per-cycle
//  restoring divider before the hand-off. The next sample is taken while the
//  previous result still waits in the output register; a result stalled
//  there holds the sequencer only in its hand-off cycle. Reset is
//  asynchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "block_average_level_meter_core_assert.svh"

module block_average_level_meter_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Sample stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [balm_pkg::LEVEL_BITS-1:0]        m_tdata,   // level
    output logic [balm_pkg::FLAG_BITS-1:0]         m_tuser,   // clipped, level_valid
    // Configuration writes.
    input  logic                                   cfg_we,
    input  logic [balm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [balm_pkg::CFG_BITS-1:0]          cfg_data
);
    import balm_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

    balm_state_t          state_reg;
    balm_state_t          state_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;

    logic [CFG_BITS-1:0]  window_length_reg;
    logic [CFG_BITS-1:0]  clip_threshold_reg;
    logic [CFG_BITS-1:0]  sample_count_reg;
    logic [CFG_BITS-1:0]  sample_count_next;
    logic                 complete_reg;
    logic                 complete_next;
    logic                 clip_latch_reg;
    logic                 clip_latch_next;
    logic [LEVEL_BITS-1:0] level_hold_reg;
    logic [LEVEL_BITS-1:0] level_hold_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [FLAG_BITS-1:0] m_tuser_reg;
    logic [FLAG_BITS-1:0] m_tuser_next;

    logic [SAMPLE_BITS-1:0] sample_v;
    logic [SAMPLE_BITS-1:0] mag;
    logic [CFG_BITS-1:0]    len_eff;
    logic [CFG_BITS-1:0]    count_inc;
    logic                   s_fire;
    logic                   step_done;
    logic                   out_free;
    logic [LEVEL_BITS-1:0]  unit_level;
    balm_ctrl_t             ctrl;

    // Magnitude of the sample; the most negative code maps to full scale.
    assign sample_v = s_tdata[SAMPLE_BITS-1:0];
    assign mag      = sample_v[SAMPLE_BITS-1] ? (~sample_v + SAMPLE_BITS'(1)) : sample_v;

    assign len_eff   = (window_length_reg < MIN_WINDOW) ? MIN_WINDOW : window_length_reg;
    assign count_inc = sample_count_reg + CFG_BITS'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign step_done = (step_reg == STEP_BITS'(SUM_BITS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    // Sequencer and per-sample bookkeeping.
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        sample_count_next = sample_count_reg;
        complete_next     = complete_reg;
        clip_latch_next   = clip_latch_reg;
        level_hold_next   = level_hold_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tuser_next      = m_tuser_reg;
        ctrl              = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    ctrl.load         = 1'b1;
                    complete_next     = (count_inc >= len_eff);
                    sample_count_next = (count_inc >= len_eff) ? '0 : count_inc;
                    if (CMP_BITS'(mag) >= CMP_BITS'(clip_threshold_reg))
                    begin
                        clip_latch_next = 1'b1;
                    end
                    step_next  = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                ctrl.add_step = 1'b1;
                ctrl.add_last = step_done;
                step_next     = step_reg + STEP_BITS'(1);
                if (step_done)
                begin
                    step_next  = '0;
                    state_next = complete_reg ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                step_next     = step_reg + STEP_BITS'(1);
                if (step_done)
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (complete_reg)
                    begin
                        level_hold_next = unit_level;
                        ctrl.clear      = 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = {clip_latch_reg, complete_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            step_reg           <= '0;
            window_length_reg  <= WINDOW_RESET;
            clip_threshold_reg <= CLIP_RESET;
            sample_count_reg   <= '0;
            complete_reg       <= 1'b0;
            clip_latch_reg     <= 1'b0;
            level_hold_reg     <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            sample_count_reg <= sample_count_next;
            complete_reg     <= complete_next;
            clip_latch_reg   <= clip_latch_next;
            level_hold_reg   <= level_hold_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH:  window_length_reg  <= cfg_data;
                    REG_CLIP_THRESHOLD: clip_threshold_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result flags ride with the output word.
    always_ff @(posedge clk)
    begin
        m_tuser_reg <= m_tuser_next;
    end

    // Serial sum and divide datapath.
    balm_serial_unit #(
        .MAG_BITS (SAMPLE_BITS)
    ) u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .mag   (mag),
        .len   (len_eff),
        .level (unit_level)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = level_hold_reg;
    assign m_tuser  = m_tuser_reg;

    `BALM_ASSERT_ALWAYS(a_step_only_busy,
                        (step_reg != '0) |-> (state_reg == ST_ADD || state_reg == ST_DIV),
                        "step counter running outside the add or divide phase")
    `BALM_ASSERT(a_accept_starts_add, s_fire |=> (state_reg == ST_ADD),
                 "accepted word did not start the serial add")
    `BALM_ASSERT(a_skip_div, (state_reg == ST_ADD && step_done && !complete_reg)
                 |=> (state_reg == ST_DONE),
                 "division entered without a closed window")
    `BALM_ASSERT(a_clip_sticky, !$fell(clip_latch_reg),
                 "clip flag cleared outside reset")

endmodule

// ===== design/balm_serial_unit.sv =====
// ---------------------------------------------------------------------------
// Block average level meter serial sum and divide unit
// Holds the magnitude sum, adds a magnitude one bit per cycle with a
// saturating carry out, and divides the sum by the window length one
// quotient bit per cycle in place.
// ---------------------------------------------------------------------------
`include "block_average_level_meter_core_assert.svh"

module balm_serial_unit #(
    parameter int MAG_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  balm_pkg::balm_ctrl_t            ctrl,
    input  logic [MAG_BITS-1:0]             mag,
    input  logic [balm_pkg::CFG_BITS-1:0]   len,
    output logic [balm_pkg::LEVEL_BITS-1:0] level
);
    import balm_pkg::*;

    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] sum_next;
    logic [MAG_BITS-1:0] mag_reg;
    logic [MAG_BITS-1:0] mag_next;
    logic                carry_reg;
    logic                carry_next;
    logic [CFG_BITS-1:0] rem_reg;
    logic [CFG_BITS-1:0] rem_next;

    logic                add_bit;
    logic                add_carry;
    logic [CFG_BITS:0]   trial;
    logic [CFG_BITS:0]   trial_diff;
    logic                trial_ge;

    // One full-adder slice on the low bits of the sum and the magnitude.
    assign add_bit   = sum_reg[0] ^ mag_reg[0] ^ carry_reg;
    assign add_carry = (sum_reg[0] & mag_reg[0]) | (sum_reg[0] & carry_reg)
                     | (mag_reg[0] & carry_reg);

    // One restoring division step: bring down the sum's top bit.
    assign trial      = {rem_reg, sum_reg[SUM_BITS-1]};
    assign trial_diff = trial - {1'b0, len};
    assign trial_ge   = (trial >= {1'b0, len});

    // Next state of the serial datapath.
    always_comb
    begin
        sum_next   = sum_reg;
        mag_next   = mag_reg;
        carry_next = carry_reg;
        rem_next   = rem_reg;
        if (ctrl.load)
        begin
            mag_next   = mag;
            carry_next = 1'b0;
            rem_next   = '0;
        end
        else if (ctrl.add_step)
        begin
            mag_next   = mag_reg >> 1;
            carry_next = add_carry;
            if (ctrl.add_last && add_carry)
            begin
                sum_next = '1;
            end
            else
            begin
                sum_next = {add_bit, sum_reg[SUM_BITS-1:1]};
            end
        end
        else if (ctrl.div_step)
        begin
            rem_next = trial_ge ? trial_diff[CFG_BITS-1:0] : trial[CFG_BITS-1:0];
            sum_next = {sum_reg[SUM_BITS-2:0], trial_ge};
        end
        else if (ctrl.clear)
        begin
            sum_next = '0;
        end
    end

    // The sum is architectural state and resets to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // Working registers of the serial steps.
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        carry_reg <= carry_next;
        rem_reg   <= rem_next;
    end

    // Quotient read out of the sum register, saturated to the level width.
    assign level = (|sum_reg[SUM_BITS-1:LEVEL_BITS]) ? '1 : sum_reg[LEVEL_BITS-1:0];

    `BALM_ASSERT(a_rem_below_len, ctrl.div_step |=> (rem_reg < len),
                 "division remainder reached the window length")
    `BALM_ASSERT(a_clear_empties, ctrl.clear |=> (sum_reg == '0),
                 "sum not empty after a window closed")

endmodule
